### sv/rcss_pkg.sv
package rcss_pkg;

  // Request types (in_tdata[2:0])
  localparam logic [2:0] REQ_INIT      = 3'd0;
  localparam logic [2:0] REQ_CLOSE     = 3'd1;
  localparam logic [2:0] REQ_EVENT     = 3'd2;
  localparam logic [2:0] REQ_BROADCAST = 3'd3;
  localparam logic [2:0] REQ_ID_REPORT = 3'd4;

  // Channel event codes
  localparam logic [2:0] EV_OK      = 3'd0;
  localparam logic [2:0] EV_TIMEOUT = 3'd1;
  localparam logic [2:0] EV_RX_FAIL = 3'd2;
  localparam logic [2:0] EV_CLOSED  = 3'd3;

  // Acknowledged command ids
  localparam logic [3:0] ACK_ASSIGN   = 4'd0;
  localparam logic [3:0] ACK_ID       = 4'd1;
  localparam logic [3:0] ACK_FREQ     = 4'd2;
  localparam logic [3:0] ACK_PERIOD   = 4'd3;
  localparam logic [3:0] ACK_TIMEOUT  = 4'd4;
  localparam logic [3:0] ACK_OPEN     = 4'd5;
  localparam logic [3:0] ACK_CLOSE    = 4'd6;
  localparam logic [3:0] ACK_UNASSIGN = 4'd7;

  // Command codes sent to the stick
  localparam logic [3:0] CMD_ASSIGN       = 4'd0;
  localparam logic [3:0] CMD_SET_ID       = 4'd1;
  localparam logic [3:0] CMD_FREQ         = 4'd2;
  localparam logic [3:0] CMD_PERIOD       = 4'd3;
  localparam logic [3:0] CMD_TIMEOUT      = 4'd4;
  localparam logic [3:0] CMD_OPEN         = 4'd5;
  localparam logic [3:0] CMD_CLOSE        = 4'd6;
  localparam logic [3:0] CMD_UNASSIGN     = 4'd7;
  localparam logic [3:0] CMD_REQ_ID       = 4'd8;
  localparam logic [3:0] CMD_INF_TIMEOUT  = 4'd9;

  // Notifications
  localparam logic [1:0] NTF_NONE     = 2'd0;
  localparam logic [1:0] NTF_TIMEOUT  = 2'd1;
  localparam logic [1:0] NTF_FOUND    = 2'd2;
  localparam logic [1:0] NTF_FINISHED = 2'd3;

  // State codes as reported on state_now
  localparam logic [3:0] SC_CLOSED     = 4'd0;
  localparam logic [3:0] SC_ASSIGNED   = 4'd1;
  localparam logic [3:0] SC_ID         = 4'd2;
  localparam logic [3:0] SC_FREQ       = 4'd3;
  localparam logic [3:0] SC_PERIOD     = 4'd4;
  localparam logic [3:0] SC_TIMEOUT    = 4'd5;
  localparam logic [3:0] SC_OPENED     = 4'd6;
  localparam logic [3:0] SC_SEARCHING  = 4'd7;
  localparam logic [3:0] SC_TRACKING   = 4'd8;
  localparam logic [3:0] SC_UNASSIGNED = 4'd9;

  // Configuration register indexes
  localparam logic [2:0] CFG_CHANNEL_NUMBER = 3'd0;
  localparam logic [2:0] CFG_SENSOR_TYPE    = 3'd1;
  localparam logic [2:0] CFG_CHANNEL_PERIOD = 3'd2;
  localparam logic [2:0] CFG_INITIAL_DEVICE = 3'd3;
  localparam logic [2:0] CFG_MASTER_MODE    = 3'd4;
  localparam logic [2:0] CFG_SEARCH_TIMEOUT = 3'd5;

  localparam logic [15:0] MASTER_CHANNEL_TYPE = 16'h0010;
  localparam logic [15:0] RST_CHANNEL_PERIOD  = 16'd8192;
  localparam logic [7:0]  RST_SEARCH_TIMEOUT  = 8'd10;

  typedef enum logic [9:0] {
    ST_CLOSED     = 10'b00_0000_0001,
    ST_ASSIGNED   = 10'b00_0000_0010,
    ST_ID         = 10'b00_0000_0100,
    ST_FREQ       = 10'b00_0000_1000,
    ST_PERIOD     = 10'b00_0001_0000,
    ST_TIMEOUT    = 10'b00_0010_0000,
    ST_OPENED     = 10'b00_0100_0000,
    ST_SEARCHING  = 10'b00_1000_0000,
    ST_TRACKING   = 10'b01_0000_0000,
    ST_UNASSIGNED = 10'b10_0000_0000
  } chan_state_t;

  typedef struct packed {
    logic        cmd_valid;
    logic [3:0]  cmd_code;
    logic [7:0]  cmd_channel;
    logic [15:0] cmd_arg;
    logic [7:0]  cmd_dev_type;
    logic [1:0]  notify;
    logic [15:0] notify_device;
    logic [3:0]  state_now;
    logic        id_mismatch;
  } result_t;

  function automatic logic [3:0] state_code(chan_state_t s);
    logic [3:0] c;
    unique case (s)
      ST_CLOSED:     c = SC_CLOSED;
      ST_ASSIGNED:   c = SC_ASSIGNED;
      ST_ID:         c = SC_ID;
      ST_FREQ:       c = SC_FREQ;
      ST_PERIOD:     c = SC_PERIOD;
      ST_TIMEOUT:    c = SC_TIMEOUT;
      ST_OPENED:     c = SC_OPENED;
      ST_SEARCHING:  c = SC_SEARCHING;
      ST_TRACKING:   c = SC_TRACKING;
      ST_UNASSIGNED: c = SC_UNASSIGNED;
      default:       c = SC_CLOSED;
    endcase
    return c;
  endfunction

endpackage

### sv/radio_channel_setup_sequencer.sv
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+-----------------------------------
// in_       | slave     | in_tvalid/in_tready  | in_tdata  32b: one host request or event
// out_      | master    | out_tvalid/out_tready| out_tdata 64b: one result per request
// cfg_      | slave     | cfg_valid/cfg_ready  | cfg_index 3b, cfg_data 16b
//
// Each request is decoded and the result register is loaded at the edge that
// accepts it, so one request per cycle is sustained while out_tready is high.
// out_tvalid rises in the cycle after the accept. The single output register
// sets the rate. in_tready drops only while a result is held and out_tready is low.
// rst_n is synchronous, active low; it empties the output and restores the state
// and configuration reset values. cfg_ready is always high.
module radio_channel_setup_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [2:0] req_type, [5:3] event_code, [9:6] ack_id, [25:10] reported_device, rest 0
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] cmd_valid, [4:1] cmd_code, [12:5] cmd_channel, [28:13] cmd_arg,
  // [36:29] cmd_dev_type, [38:37] notify, [54:39] notify_device,
  // [58:55] state_now, [59] id_mismatch, [63:60] zero
  output logic [63:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration registers
  logic [7:0]  channel_number_r;
  logic [7:0]  sensor_type_r;
  logic [15:0] channel_period_r;
  logic [15:0] initial_device_r;
  logic        master_mode_r;
  logic [7:0]  search_timeout_r;

  // Channel state and paired device
  rcss_pkg::chan_state_t state_r, state_nxt;
  logic [15:0] device_r, device_nxt;

  // Result register
  logic              out_valid_r;
  rcss_pkg::result_t res_r, res_nxt;

  logic        in_acc;
  logic [2:0]  req_type;
  logic [2:0]  event_code;
  logic [3:0]  ack_id;
  logic [15:0] reported_device;
  logic [3:0]  ack_expect;
  logic        ack_checked;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  assign req_type        = in_tdata[2:0];
  assign event_code      = in_tdata[5:3];
  assign ack_id          = in_tdata[9:6];
  assign reported_device = in_tdata[25:10];

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, res_r.id_mismatch, res_r.state_now, res_r.notify_device,
                       res_r.notify, res_r.cmd_dev_type, res_r.cmd_arg,
                       res_r.cmd_channel, res_r.cmd_code, res_r.cmd_valid};

  // Command id each state waits for on an ok response; searching expects none.
  always_comb begin
    ack_checked = 1'b1;
    ack_expect  = rcss_pkg::ACK_ASSIGN;
    unique case (state_r)
      rcss_pkg::ST_ASSIGNED:   ack_expect = rcss_pkg::ACK_ASSIGN;
      rcss_pkg::ST_ID:         ack_expect = rcss_pkg::ACK_ID;
      rcss_pkg::ST_FREQ:       ack_expect = rcss_pkg::ACK_FREQ;
      rcss_pkg::ST_PERIOD:     ack_expect = rcss_pkg::ACK_PERIOD;
      rcss_pkg::ST_TIMEOUT:    ack_expect = rcss_pkg::ACK_TIMEOUT;
      rcss_pkg::ST_OPENED:     ack_expect = rcss_pkg::ACK_OPEN;
      rcss_pkg::ST_CLOSED:     ack_expect = rcss_pkg::ACK_CLOSE;
      rcss_pkg::ST_UNASSIGNED: ack_expect = rcss_pkg::ACK_UNASSIGN;
      // tracking waits for the timeout acknowledge of the infinite timeout command
      rcss_pkg::ST_TRACKING:   ack_expect = rcss_pkg::ACK_TIMEOUT;
      rcss_pkg::ST_SEARCHING:  ack_checked = 1'b0;
      default:                 ack_checked = 1'b0;
    endcase
  end

  // Decode one request into the next state and its result.
  always_comb begin
    state_nxt  = state_r;
    device_nxt = device_r;
    res_nxt    = '0;

    case (req_type)
      rcss_pkg::REQ_INIT: begin
        device_nxt          = initial_device_r;
        res_nxt.cmd_valid   = 1'b1;
        res_nxt.cmd_code    = rcss_pkg::CMD_ASSIGN;
        res_nxt.cmd_arg     = master_mode_r ? rcss_pkg::MASTER_CHANNEL_TYPE : 16'd0;
        state_nxt           = rcss_pkg::ST_ASSIGNED;
      end
      rcss_pkg::REQ_CLOSE: begin
        res_nxt.cmd_valid = 1'b1;
        res_nxt.cmd_code  = rcss_pkg::CMD_CLOSE;
        state_nxt         = rcss_pkg::ST_CLOSED;
      end
      rcss_pkg::REQ_EVENT: begin
        case (event_code)
          rcss_pkg::EV_OK: begin
            res_nxt.id_mismatch = ack_checked && (ack_id != ack_expect);
            unique case (state_r)
              rcss_pkg::ST_ASSIGNED: begin
                res_nxt.cmd_valid    = 1'b1;
                res_nxt.cmd_code     = rcss_pkg::CMD_SET_ID;
                res_nxt.cmd_arg      = device_r;
                res_nxt.cmd_dev_type = sensor_type_r;
                state_nxt            = rcss_pkg::ST_ID;
              end
              rcss_pkg::ST_ID: begin
                res_nxt.cmd_valid = 1'b1;
                res_nxt.cmd_code  = rcss_pkg::CMD_FREQ;
                state_nxt         = rcss_pkg::ST_FREQ;
              end
              rcss_pkg::ST_FREQ: begin
                res_nxt.cmd_valid = 1'b1;
                res_nxt.cmd_code  = rcss_pkg::CMD_PERIOD;
                res_nxt.cmd_arg   = channel_period_r;
                state_nxt         = rcss_pkg::ST_PERIOD;
              end
              rcss_pkg::ST_PERIOD: begin
                // master skips the search timeout step
                res_nxt.cmd_valid = 1'b1;
                if (master_mode_r) begin
                  res_nxt.cmd_code = rcss_pkg::CMD_OPEN;
                  state_nxt        = rcss_pkg::ST_OPENED;
                end else begin
                  res_nxt.cmd_code = rcss_pkg::CMD_TIMEOUT;
                  res_nxt.cmd_arg  = {8'd0, search_timeout_r};
                  state_nxt        = rcss_pkg::ST_TIMEOUT;
                end
              end
              rcss_pkg::ST_TIMEOUT: begin
                res_nxt.cmd_valid = 1'b1;
                res_nxt.cmd_code  = rcss_pkg::CMD_OPEN;
                state_nxt         = rcss_pkg::ST_OPENED;
              end
              rcss_pkg::ST_OPENED: begin
                state_nxt = rcss_pkg::ST_SEARCHING;
              end
              rcss_pkg::ST_UNASSIGNED: begin
                res_nxt.notify = rcss_pkg::NTF_FINISHED;
              end
              default: begin
                // closed, searching, tracking: hold state
              end
            endcase
          end
          rcss_pkg::EV_TIMEOUT: begin
            res_nxt.notify    = rcss_pkg::NTF_TIMEOUT;
            res_nxt.cmd_valid = 1'b1;
            res_nxt.cmd_code  = rcss_pkg::CMD_UNASSIGN;
            state_nxt         = rcss_pkg::ST_UNASSIGNED;
          end
          rcss_pkg::EV_CLOSED: begin
            if (state_r != rcss_pkg::ST_UNASSIGNED) begin
              res_nxt.cmd_valid = 1'b1;
              res_nxt.cmd_code  = rcss_pkg::CMD_UNASSIGN;
              state_nxt         = rcss_pkg::ST_UNASSIGNED;
            end
          end
          default: begin
            // rx fail and other events: drop
          end
        endcase
      end
      rcss_pkg::REQ_BROADCAST: begin
        if (state_r == rcss_pkg::ST_SEARCHING) begin
          res_nxt.cmd_valid = 1'b1;
          res_nxt.cmd_code  = rcss_pkg::CMD_REQ_ID;
          state_nxt         = rcss_pkg::ST_TRACKING;
        end
      end
      rcss_pkg::REQ_ID_REPORT: begin
        device_nxt            = reported_device;
        state_nxt             = rcss_pkg::ST_TRACKING;
        res_nxt.notify        = rcss_pkg::NTF_FOUND;
        res_nxt.notify_device = reported_device;
        res_nxt.cmd_valid     = 1'b1;
        res_nxt.cmd_code      = rcss_pkg::CMD_INF_TIMEOUT;
      end
      default: begin
        // unknown request: no command, no change
      end
    endcase

    if (res_nxt.cmd_valid) begin
      res_nxt.cmd_channel = channel_number_r;
    end
    res_nxt.state_now = rcss_pkg::state_code(state_nxt);
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_number_r <= 8'd0;
      sensor_type_r    <= 8'd0;
      channel_period_r <= rcss_pkg::RST_CHANNEL_PERIOD;
      initial_device_r <= 16'd0;
      master_mode_r    <= 1'b0;
      search_timeout_r <= rcss_pkg::RST_SEARCH_TIMEOUT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rcss_pkg::CFG_CHANNEL_NUMBER: channel_number_r <= cfg_data[7:0];
        rcss_pkg::CFG_SENSOR_TYPE:    sensor_type_r    <= cfg_data[7:0];
        rcss_pkg::CFG_CHANNEL_PERIOD: channel_period_r <= cfg_data;
        rcss_pkg::CFG_INITIAL_DEVICE: initial_device_r <= cfg_data;
        rcss_pkg::CFG_MASTER_MODE:    master_mode_r    <= cfg_data[0];
        rcss_pkg::CFG_SEARCH_TIMEOUT: search_timeout_r <= cfg_data[7:0];
        default: begin
          // writes past the register list are dropped
        end
      endcase
    end
  end

  // Channel state and device are loaded from the decode on every accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= rcss_pkg::ST_CLOSED;
      device_r <= 16'd0;
    end else if (in_acc) begin
      state_r  <= state_nxt;
      device_r <= device_nxt;
    end
  end

  // Output register: load on accept, clear valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

endmodule

### sv/rcss_checker.sv
module rcss_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  // A held result stays put until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // A close request yields a close command and the closed state next cycle.
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata[2:0] == rcss_pkg::REQ_CLOSE) |=>
      out_tvalid && out_tdata[0] && (out_tdata[4:1] == rcss_pkg::CMD_CLOSE) &&
      (out_tdata[58:55] == rcss_pkg::SC_CLOSED))
    else $error("close request not answered by close command");

  // Without a command every command field reads zero.
  a_no_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> (out_tdata[36:1] == 36'd0))
    else $error("command fields set without a command");

  // Device number only travels with a sensor found notification.
  a_notify_dev: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[38:37] != rcss_pkg::NTF_FOUND) |->
      (out_tdata[54:39] == 16'd0))
    else $error("notify device set without sensor found");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind radio_channel_setup_sequencer rcss_checker u_rcss_checker (.*);

### sim/tb_radio_channel_setup_sequencer.sv
module tb_radio_channel_setup_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  // Field values the package leaves unnamed
  localparam logic [3:0] ACK_OTHER   = 4'd8;
  localparam logic [2:0] EV_OTHER    = 3'd4;
  localparam logic [2:0] EV_UNKNOWN  = 3'd7;
  localparam logic [2:0] REQ_UNKNOWN = 3'd7;

  // Cycles with no handshake on any channel before the run is declared hung
  localparam int unsigned QUIET_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // [2:0] req_type, [5:3] event_code, [9:6] ack_id, [25:10] reported_device, rest 0
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  // [0] cmd_valid, [4:1] cmd_code, [12:5] cmd_channel, [28:13] cmd_arg,
  // [36:29] cmd_dev_type, [38:37] notify, [54:39] notify_device,
  // [58:55] state_now, [59] id_mismatch
  logic [63:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  radio_channel_setup_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // Shadow copy of the configuration registers
  logic [7:0]  reg_channel;
  logic [7:0]  reg_sensor_type;
  logic [15:0] reg_period;
  logic [15:0] reg_initial_device;
  logic        reg_master;
  logic [7:0]  reg_search_timeout;

  // Shadow copy of the channel state
  logic [3:0]  model_state;
  logic [15:0] model_device;

  rcss_pkg::result_t predicted_replies [$];
  int unsigned items_sent;
  int unsigned replies_seen;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;
  bit          idle_on = 1'b1;

  // Mostly back-to-back, sometimes a short gap, rarely a long pause.
  function automatic int unsigned idle_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic string show_reply(input rcss_pkg::result_t r);
    return $sformatf({"cmd_valid=%0d code=%0d chan=%0d arg=%0d dev_type=%0d ",
                      "notify=%0d notify_dev=%0d state=%0d id_mismatch=%0d"},
                     r.cmd_valid, r.cmd_code, r.cmd_channel, r.cmd_arg, r.cmd_dev_type,
                     r.notify, r.notify_device, r.state_now, r.id_mismatch);
  endfunction

  // Predict the reply to one request and advance the shadow state.
  function automatic rcss_pkg::result_t advance_channel(
      input logic [2:0] req, input logic [2:0] ev,
      input logic [3:0] ack, input logic [15:0] dev);
    rcss_pkg::result_t r;
    logic        issue;
    logic [3:0]  code;
    logic [15:0] arg;
    logic [7:0]  dtype;
    logic        check_ack;
    logic [3:0]  want_ack;
    r         = '0;
    issue     = 1'b0;
    code      = '0;
    arg       = '0;
    dtype     = '0;
    check_ack = 1'b0;
    want_ack  = '0;
    case (req)
      rcss_pkg::REQ_INIT: begin
        model_device = reg_initial_device;
        issue        = 1'b1;
        code         = rcss_pkg::CMD_ASSIGN;
        arg          = reg_master ? rcss_pkg::MASTER_CHANNEL_TYPE : 16'h0000;
        model_state  = rcss_pkg::SC_ASSIGNED;
      end
      rcss_pkg::REQ_CLOSE: begin
        model_state = rcss_pkg::SC_CLOSED;
        issue       = 1'b1;
        code        = rcss_pkg::CMD_CLOSE;
      end
      rcss_pkg::REQ_EVENT: begin
        if (ev == rcss_pkg::EV_OK) begin
          // Every state except searching checks the acknowledged id.
          check_ack = 1'b1;
          case (model_state)
            rcss_pkg::SC_ASSIGNED: begin
              want_ack    = rcss_pkg::ACK_ASSIGN;
              issue       = 1'b1;
              code        = rcss_pkg::CMD_SET_ID;
              arg         = model_device;
              dtype       = reg_sensor_type;
              model_state = rcss_pkg::SC_ID;
            end
            rcss_pkg::SC_ID: begin
              want_ack    = rcss_pkg::ACK_ID;
              issue       = 1'b1;
              code        = rcss_pkg::CMD_FREQ;
              model_state = rcss_pkg::SC_FREQ;
            end
            rcss_pkg::SC_FREQ: begin
              want_ack    = rcss_pkg::ACK_FREQ;
              issue       = 1'b1;
              code        = rcss_pkg::CMD_PERIOD;
              arg         = reg_period;
              model_state = rcss_pkg::SC_PERIOD;
            end
            rcss_pkg::SC_PERIOD: begin
              want_ack = rcss_pkg::ACK_PERIOD;
              issue    = 1'b1;
              // A master skips the search timeout step.
              if (reg_master) begin
                code        = rcss_pkg::CMD_OPEN;
                model_state = rcss_pkg::SC_OPENED;
              end else begin
                code        = rcss_pkg::CMD_TIMEOUT;
                arg         = {8'h00, reg_search_timeout};
                model_state = rcss_pkg::SC_TIMEOUT;
              end
            end
            rcss_pkg::SC_TIMEOUT: begin
              want_ack    = rcss_pkg::ACK_TIMEOUT;
              issue       = 1'b1;
              code        = rcss_pkg::CMD_OPEN;
              model_state = rcss_pkg::SC_OPENED;
            end
            rcss_pkg::SC_OPENED: begin
              want_ack    = rcss_pkg::ACK_OPEN;
              model_state = rcss_pkg::SC_SEARCHING;
            end
            rcss_pkg::SC_CLOSED:   want_ack = rcss_pkg::ACK_CLOSE;
            rcss_pkg::SC_TRACKING: want_ack = rcss_pkg::ACK_TIMEOUT;
            rcss_pkg::SC_UNASSIGNED: begin
              want_ack = rcss_pkg::ACK_UNASSIGN;
              r.notify = rcss_pkg::NTF_FINISHED;
            end
            default: check_ack = 1'b0;
          endcase
        end else if (ev == rcss_pkg::EV_TIMEOUT) begin
          r.notify    = rcss_pkg::NTF_TIMEOUT;
          issue       = 1'b1;
          code        = rcss_pkg::CMD_UNASSIGN;
          model_state = rcss_pkg::SC_UNASSIGNED;
        end else if (ev == rcss_pkg::EV_CLOSED &&
                     model_state != rcss_pkg::SC_UNASSIGNED) begin
          issue       = 1'b1;
          code        = rcss_pkg::CMD_UNASSIGN;
          model_state = rcss_pkg::SC_UNASSIGNED;
        end
      end
      rcss_pkg::REQ_BROADCAST: begin
        if (model_state == rcss_pkg::SC_SEARCHING) begin
          issue       = 1'b1;
          code        = rcss_pkg::CMD_REQ_ID;
          model_state = rcss_pkg::SC_TRACKING;
        end
      end
      rcss_pkg::REQ_ID_REPORT: begin
        model_device    = dev;
        model_state     = rcss_pkg::SC_TRACKING;
        r.notify        = rcss_pkg::NTF_FOUND;
        r.notify_device = dev;
        issue           = 1'b1;
        code            = rcss_pkg::CMD_INF_TIMEOUT;
      end
      default: ;
    endcase
    r.id_mismatch = check_ack && (ack != want_ack);
    r.cmd_valid   = issue;
    if (issue) begin
      r.cmd_code     = code;
      r.cmd_channel  = reg_channel;
      r.cmd_arg      = arg;
      r.cmd_dev_type = dtype;
    end
    r.state_now = model_state;
    return r;
  endfunction

  // Present one request after a random gap, hold it until accepted, then log the
  // predicted reply. Leave tvalid high so a back-to-back request needs no toggle.
  task automatic push_request(input logic [2:0] req, input logic [2:0] ev,
                              input logic [3:0] ack, input logic [15:0] dev);
    int unsigned gap;
    gap = idle_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, dev, ack, ev, req};
    do @(posedge clk); while (!in_tready);
    predicted_replies.push_back(advance_channel(req, ev, ack, dev));
    items_sent++;
  endtask

  task automatic push_noise();
    push_request(3'($urandom), 3'($urandom), 4'($urandom), 16'($urandom));
  endtask

  // Drop the request valid and hold until every predicted reply has arrived.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (predicted_replies.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write all six registers back to back while the block is idle. Upper data bits
  // beyond a register's width carry whatever the caller passes.
  task automatic apply_setting(input logic [15:0] chan, stype, period, idev, master, tmo);
    logic [2:0]  idx  [6];
    logic [15:0] data [6];
    idx  = '{rcss_pkg::CFG_CHANNEL_NUMBER, rcss_pkg::CFG_SENSOR_TYPE,
             rcss_pkg::CFG_CHANNEL_PERIOD, rcss_pkg::CFG_INITIAL_DEVICE,
             rcss_pkg::CFG_MASTER_MODE, rcss_pkg::CFG_SEARCH_TIMEOUT};
    data = '{chan, stype, period, idev, master, tmo};
    wait_drained();
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= data[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        rcss_pkg::CFG_CHANNEL_NUMBER: reg_channel        = data[i][7:0];
        rcss_pkg::CFG_SENSOR_TYPE:    reg_sensor_type    = data[i][7:0];
        rcss_pkg::CFG_CHANNEL_PERIOD: reg_period         = data[i];
        rcss_pkg::CFG_INITIAL_DEVICE: reg_initial_device = data[i];
        rcss_pkg::CFG_MASTER_MODE:    reg_master         = data[i][0];
        rcss_pkg::CFG_SEARCH_TIMEOUT: reg_search_timeout = data[i][7:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // One channel bring-up with random content: init, the acknowledge chain, then
  // find and track a sensor or time out, then tear down. Acks are sometimes wrong, stray
  // events slip in, and a few sessions break off partway.
  task automatic run_session();
    logic [3:0] steps [6];
    steps = '{rcss_pkg::ACK_ASSIGN, rcss_pkg::ACK_ID, rcss_pkg::ACK_FREQ,
              rcss_pkg::ACK_PERIOD, rcss_pkg::ACK_TIMEOUT, rcss_pkg::ACK_OPEN};
    push_request(rcss_pkg::REQ_INIT, 3'($urandom), 4'($urandom), 16'($urandom));
    foreach (steps[i]) begin
      if (steps[i] == rcss_pkg::ACK_TIMEOUT && reg_master) continue;
      if ($urandom_range(0, 39) == 0) return;
      if ($urandom_range(0, 14) == 0)
        push_request(rcss_pkg::REQ_EVENT, rcss_pkg::EV_RX_FAIL, 4'($urandom),
                     16'($urandom));
      push_request(rcss_pkg::REQ_EVENT, rcss_pkg::EV_OK,
                   ($urandom_range(0, 9) == 0) ? 4'($urandom) : steps[i], 16'($urandom));
    end
    if ($urandom_range(0, 3) == 0)
      push_request(rcss_pkg::REQ_EVENT, rcss_pkg::EV_OK, 4'($urandom), 16'($urandom));
    if ($urandom_range(0, 5) == 0) begin
      push_request(rcss_pkg::REQ_EVENT, rcss_pkg::EV_TIMEOUT, 4'($urandom),
                   16'($urandom));
    end else begin
      push_request(rcss_pkg::REQ_BROADCAST, 3'($urandom), 4'($urandom), 16'($urandom));
      push_request(rcss_pkg::REQ_ID_REPORT, 3'($urandom), 4'($urandom), 16'($urandom));
      repeat ($urandom_range(0, 3))
        push_request(rcss_pkg::REQ_BROADCAST + 3'($urandom_range(0, 1)) - 3'd1,
                     rcss_pkg::EV_OK,
                     ($urandom_range(0, 3) == 0) ? 4'($urandom) : rcss_pkg::ACK_TIMEOUT,
                     16'($urandom));
    end
    case ($urandom_range(0, 3))
      0: push_request(rcss_pkg::REQ_EVENT, rcss_pkg::EV_TIMEOUT, 4'($urandom),
                      16'($urandom));
      1: push_request(rcss_pkg::REQ_EVENT, rcss_pkg::EV_CLOSED, 4'($urandom),
                      16'($urandom));
      2: push_request(rcss_pkg::REQ_CLOSE, 3'($urandom), 4'($urandom), 16'($urandom));
      default: return;
    endcase
    if ($urandom_range(0, 1) == 0)
      push_request(rcss_pkg::REQ_EVENT, rcss_pkg::EV_OK,
                   ($urandom_range(0, 3) == 0) ? 4'($urandom) : rcss_pkg::ACK_UNASSIGN,
                   16'($urandom));
  endtask

  // Walk the slave setup at reset configuration and hit each corner case once.
  task automatic test_slave_setup();
    // id check while closed, then a wrong id while closed
    push_request(rcss_pkg::REQ_EVENT, rcss_pkg::EV_OK, rcss_pkg::ACK_CLOSE, 16'h0000);
    push_request(rcss_pkg::REQ_EVENT, rcss_pkg::EV_OK, 4'hF, 16'h0000);
    push_request(rcss_pkg::REQ_INIT, rcss_pkg::EV_OK, rcss_pkg::ACK_ASSIGN, 16'h0000);
    push_request(rcss_pkg::REQ_EVENT, rcss_pkg::EV_OK, rcss_pkg::ACK_ASSIGN, 16'h0000);
    push_request(rcss_pkg::REQ_EVENT, rcss_pkg::EV_OK, rcss_pkg::ACK_ID, 16'h0000);
    // wrong id still advances
    push_request(rcss_pkg::REQ_EVENT, rcss_pkg::EV_OK, rcss_pkg::ACK_UNASSIGN, 16'h0000);
    push_request(rcss_pkg::REQ_EVENT, rcss_pkg::EV_OK, rcss_pkg::ACK_PERIOD, 16'h0000);
    // broadcast before search
    push_request(rcss_pkg::REQ_BROADCAST, rcss_pkg::EV_OK, rcss_pkg::ACK_ASSIGN, 16'h0000);
    push_request(rcss_pkg::REQ_EVENT, rcss_pkg::EV_OK, rcss_pkg::ACK_TIMEOUT, 16'h0000);
    push_request(rcss_pkg::REQ_EVENT, rcss_pkg::EV_OK, rcss_pkg::ACK_OPEN, 16'h0000);
    // ok while searching
    push_request(rcss_pkg::REQ_EVENT, rcss_pkg::EV_OK, rcss_pkg::ACK_ASSIGN, 16'h0000);
    push_request(rcss_pkg::REQ_BROADCAST, rcss_pkg::EV_OK, rcss_pkg::ACK_ASSIGN, 16'h0000);
    push_request(rcss_pkg::REQ_ID_REPORT, rcss_pkg::EV_OK, rcss_pkg::ACK_ASSIGN, 16'hFFFF);
    push_request(rcss_pkg::REQ_EVENT, rcss_pkg::EV_OK, rcss_pkg::ACK_TIMEOUT, 16'h0000);
    // wrong id while tracking
    push_request(rcss_pkg::REQ_EVENT, rcss_pkg::EV_OK, rcss_pkg::ACK_OPEN, 16'h0000);
    push_request(rcss_pkg::REQ_EVENT, rcss_pkg::EV_RX_FAIL, rcss_pkg::ACK_ASSIGN,
                 16'h0000);
    push_request(rcss_pkg::REQ_EVENT, EV_OTHER, rcss_pkg::ACK_ASSIGN, 16'h0000);
    push_request(rcss_pkg::REQ_EVENT, EV_UNKNOWN, 4'hF, 16'hFFFF);
    push_request(REQ_UNKNOWN, EV_UNKNOWN, 4'hF, 16'hFFFF);
    push_request(rcss_pkg::REQ_EVENT, rcss_pkg::EV_TIMEOUT, rcss_pkg::ACK_ASSIGN,
                 16'h0000);
    // finished, then finished with a wrong id
    push_request(rcss_pkg::REQ_EVENT, rcss_pkg::EV_OK, rcss_pkg::ACK_UNASSIGN, 16'h0000);
    push_request(rcss_pkg::REQ_EVENT, rcss_pkg::EV_OK, ACK_OTHER, 16'h0000);
    // closed while unassigned
    push_request(rcss_pkg::REQ_EVENT, rcss_pkg::EV_CLOSED, rcss_pkg::ACK_ASSIGN,
                 16'h0000);
    push_request(rcss_pkg::REQ_CLOSE, rcss_pkg::EV_OK, rcss_pkg::ACK_ASSIGN, 16'h0000);
    push_request(rcss_pkg::REQ_EVENT, rcss_pkg::EV_CLOSED, rcss_pkg::ACK_ASSIGN,
                 16'h0000);
    push_request(rcss_pkg::REQ_ID_REPORT, rcss_pkg::EV_OK, rcss_pkg::ACK_ASSIGN, 16'h0000);
  endtask

  // Master path with every register at its top value.
  task automatic test_master_setup();
    apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_request(rcss_pkg::REQ_INIT, rcss_pkg::EV_OK, rcss_pkg::ACK_ASSIGN, 16'h0000);
    push_request(rcss_pkg::REQ_EVENT, rcss_pkg::EV_OK, rcss_pkg::ACK_ASSIGN, 16'h0000);
    push_request(rcss_pkg::REQ_EVENT, rcss_pkg::EV_OK, rcss_pkg::ACK_ID, 16'h0000);
    push_request(rcss_pkg::REQ_EVENT, rcss_pkg::EV_OK, rcss_pkg::ACK_FREQ, 16'h0000);
    // straight to open
    push_request(rcss_pkg::REQ_EVENT, rcss_pkg::EV_OK, rcss_pkg::ACK_PERIOD, 16'h0000);
    push_request(rcss_pkg::REQ_EVENT, rcss_pkg::EV_OK, rcss_pkg::ACK_OPEN, 16'h0000);
    push_request(rcss_pkg::REQ_BROADCAST, rcss_pkg::EV_OK, rcss_pkg::ACK_ASSIGN, 16'h0000);
    push_request(rcss_pkg::REQ_EVENT, rcss_pkg::EV_CLOSED, rcss_pkg::ACK_ASSIGN,
                 16'h0000);
  endtask

  // Random sessions mixed with noise. Halfway, hold the sender until every reply
  // is in; a calm start runs the first half with no idling on either side.
  task automatic test_mixed_traffic(input int unsigned target, input bit calm_start);
    int unsigned first;
    bit          paused;
    first   = items_sent;
    paused  = 1'b0;
    idle_on = !calm_start;
    while (items_sent - first < target) begin
      if (!paused && items_sent - first >= target / 2) begin
        paused  = 1'b1;
        idle_on = 1'b1;
        wait_drained();
      end
      if ($urandom_range(0, 3) != 0) run_session();
      else repeat ($urandom_range(1, 4)) push_noise();
    end
  endtask

  // Receiver pacing: runs of ready, then, while idling is on, stalls of random length.
  initial begin : reply_pacing
    int unsigned n;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      out_tready <= 1'b1;
      n = idle_on ? $urandom_range(1, 12) : 50;
      repeat (n) @(posedge clk);
      if (idle_on) begin
        out_tready <= 1'b0;
        repeat (1 + idle_gap()) @(posedge clk);
      end
    end
  end

  // Compare each accepted reply against the oldest prediction.
  always @(posedge clk) begin : reply_check
    rcss_pkg::result_t got;
    rcss_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.cmd_valid     = out_tdata[0];
      got.cmd_code      = out_tdata[4:1];
      got.cmd_channel   = out_tdata[12:5];
      got.cmd_arg       = out_tdata[28:13];
      got.cmd_dev_type  = out_tdata[36:29];
      got.notify        = out_tdata[38:37];
      got.notify_device = out_tdata[54:39];
      got.state_now     = out_tdata[58:55];
      got.id_mismatch   = out_tdata[59];
      replies_seen++;
      if (predicted_replies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("reply %0d with no request pending: %s", replies_seen, show_reply(got));
      end else begin
        want = predicted_replies.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("reply %0d expected %s", replies_seen, show_reply(want));
            $display("reply %0d actual   %s", replies_seen, show_reply(got));
          end
        end
      end
    end
  end

  // Watchdog: end the run if no channel moves anything for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    rst_n        <= 1'b0;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    quiet_cycles <= 0;

    // Shadow state starts at the block's reset values.
    reg_channel        = 8'h00;
    reg_sensor_type    = 8'h00;
    reg_period         = rcss_pkg::RST_CHANNEL_PERIOD;
    reg_initial_device = 16'h0000;
    reg_master         = 1'b0;
    reg_search_timeout = rcss_pkg::RST_SEARCH_TIMEOUT;
    model_state        = rcss_pkg::SC_CLOSED;
    model_device       = 16'h0000;
    items_sent         = 0;
    replies_seen       = 0;
    mismatch_count     = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_slave_setup();
    test_master_setup();

    apply_setting(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    test_mixed_traffic(95, 1'b0);
    apply_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
    test_mixed_traffic(95, 1'b1);
    apply_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'h0001, 16'($urandom));
    test_mixed_traffic(95, 1'b0);
    apply_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'h0000, 16'($urandom));
    test_mixed_traffic(95, 1'b0);

    // Drain, let the output register settle, then judge.
    wait_drained();
    repeat (4) @(posedge clk);
    if (predicted_replies.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
